FILE: rtl/core/sgdb_pkg.sv
// Package: shared types, register codes and tap arithmetic of the depth blur.
`timescale 1ns / 1ps

package sgdb_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_W = 11;
  localparam int PIX_W = 16;
  localparam int NUM_SLOTS = 6;
  localparam int TAPS = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_COEF_CENTER  = 3'd2,
    CFG_COEF_ONE     = 3'd3,
    CFG_COEF_TWO     = 3'd4,
    CFG_COEF_THREE   = 3'd5
  } cfg_idx_t;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
  localparam logic [15:0] RST_COEF_CENTER = 16'd30870;
  localparam logic [15:0] RST_COEF_ONE    = 16'd15402;
  localparam logic [15:0] RST_COEF_TWO    = 16'd1877;
  localparam logic [15:0] RST_COEF_THREE  = 16'd54;

  typedef struct packed {
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
  } coef_t;

  function automatic logic [15:0] coef_sel(coef_t c, logic [1:0] offs);
    logic [15:0] r;
    case (offs)
      2'd0: r = c.c0;
      2'd1: r = c.c1;
      2'd2: r = c.c2;
      default: r = c.c3;
    endcase
    return r;
  endfunction

  // floor(coef * value / 2^16)
  function automatic logic [PIX_W-1:0] tap(logic [15:0] c, logic [PIX_W-1:0] v);
    logic [31:0] p;
    p = {16'd0, c} * {16'd0, v};
    return p[31:16];
  endfunction

endpackage

FILE: rtl/core/sgdb_in_if.sv
// Interface: input pixel channel.
`timescale 1ns / 1ps

interface sgdb_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] depth_in;

  modport source (output valid, output kind, output depth_in, input ready);
  modport sink (input valid, input kind, input depth_in, output ready);
endinterface

FILE: rtl/core/sgdb_out_if.sv
// Interface: blurred result channel.
`timescale 1ns / 1ps

interface sgdb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] blurred;
  logic        frame_last;

  modport source (output valid, output blurred, output frame_last, input ready);
  modport sink (input valid, input blurred, input frame_last, output ready);
endinterface

FILE: rtl/core/separable_gaussian_depth_blur.sv
// Top level: separable 7-tap depth blur with configuration registers.
`timescale 1ns / 1ps

// Usage
//   in_ch  : valid/ready stream of {kind, depth_in}; kind 0 is a pixel, kind 1 a
//            drain step. A transaction completes when valid and ready are high.
//   out_ch : valid/ready stream of {blurred, frame_last}, raster order.
//   cfg_*  : write-only port; cfg_we writes cfg_data to register cfg_index.
//            Write only while idle. Width/height are latched on a frame's
//            first pixel; coefficients apply at once.
// Results trail the input by 3*W+3 positions; after the last pixel send
// 3*W+3 drain transactions to flush the frame (drains sent earlier are dropped).
// Timing: one transaction per cycle sustained while out_ch is not held. A result
// reaches out_ch through the pipeline: the pop out of the queue loads the first
// of four filter stages, then three more stages and the output register.
// Stall: when out_ch is held, the filter stages freeze; the 4-entry queue
// fills, then in_ch.ready drops. Nothing is lost.
// Reset (rst_n low, synchronous): positions, window and registers return to
// defaults. Line stores are not cleared; no row outside the frame is ever read.
module separable_gaussian_depth_blur #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sgdb_in_if.sink                         in_ch,
  sgdb_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [sgdb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgdb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sgdb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QDEPTH = 4;

  // one classified item, front to back
  typedef struct packed {
    logic [15:0]   pix;
    logic [CW-1:0] hc;      // column of the horizontal (and output) position
    logic [2:0]    hm6;     // row slot written by the horizontal result
    logic          have_h;
    logic          have_v;
    logic          last;
    logic [6:0]    hmask;
    logic [6:0]    vmask;
  } entry_t;

  logic [DIM_W-1:0] cfg_w_r, cfg_h_r;
  coef_t            coef_r;

  entry_t f_entry, q_head;
  logic   q_push, q_pop, q_nempty, q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= RST_IMAGE_WIDTH;
      cfg_h_r   <= RST_IMAGE_HEIGHT;
      coef_r.c0 <= RST_COEF_CENTER;
      coef_r.c1 <= RST_COEF_ONE;
      coef_r.c2 <= RST_COEF_TWO;
      coef_r.c3 <= RST_COEF_THREE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  cfg_w_r   <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_h_r   <= cfg_data[DIM_W-1:0];
        CFG_COEF_CENTER:  coef_r.c0 <= cfg_data;
        CFG_COEF_ONE:     coef_r.c1 <= cfg_data;
        CFG_COEF_TWO:     coef_r.c2 <= cfg_data;
        CFG_COEF_THREE:   coef_r.c3 <= cfg_data;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  sgdb_front #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .entry_t(entry_t)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cfg_w(cfg_w_r), .cfg_h(cfg_h_r),
    .q_full(q_full), .q_push(q_push), .q_entry(f_entry)
  );

  sgdb_queue #(.DEPTH(QDEPTH), .entry_t(entry_t)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data(f_entry),
    .pop(q_pop), .head(q_head), .nempty(q_nempty), .full(q_full)
  );

  sgdb_back #(.MAX_WIDTH(MAX_WIDTH), .entry_t(entry_t)) u_back (
    .clk(clk), .rst_n(rst_n), .coefs(coef_r),
    .q_head(q_head), .q_nempty(q_nempty), .q_pop(q_pop),
    .out_ch(out_ch)
  );

  // a held result freezes the filter: nothing leaves the queue
  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !q_pop)
    else $error("queue popped while output stalled");

  a_pop_nempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nempty)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

FILE: rtl/core/sgdb_front.sv
// Front end: accepts transactions, tracks raster position, classifies each item.
`timescale 1ns / 1ps

module sgdb_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter type entry_t = logic
) (
  input  logic                        clk,
  input  logic                        rst_n,
  sgdb_in_if.sink                     in_ch,
  input  logic [sgdb_pkg::DIM_W-1:0]  cfg_w,
  input  logic [sgdb_pkg::DIM_W-1:0]  cfg_h,
  input  logic                        q_full,
  output logic                        q_push,
  output entry_t                      q_entry
);
  import sgdb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 4);

  logic [WW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [2:0]    row_m6_r, row_m6_nxt;
  logic [WW-1:0] act_w_r;
  logic [HW-1:0] act_h_r;

  logic          accept, sample, beyond, drop, k_ge3, col_ge3, last;
  logic          have_h, have_v;
  logic [WW-1:0] w, cw_clamp, hc_w;
  logic [HW-1:0] h, ch_clamp;
  logic [RW-1:0] hrow, orow, h_r;
  logic [2:0]    hm6;
  logic [6:0]    hmask, vmask;

  always_comb begin
    if ({21'd0, cfg_w} < 32'd8) cw_clamp = WW'(8);
    else if ({21'd0, cfg_w} > 32'(MAX_WIDTH)) cw_clamp = WW'(MAX_WIDTH);
    else cw_clamp = WW'(cfg_w);
    if ({21'd0, cfg_h} < 32'd8) ch_clamp = HW'(8);
    else if ({21'd0, cfg_h} > 32'(MAX_HEIGHT)) ch_clamp = HW'(MAX_HEIGHT);
    else ch_clamp = HW'(cfg_h);
  end

  assign in_ch.ready = !q_full;
  assign accept  = in_ch.valid && !q_full;
  assign sample  = (in_col_r == '0) && (in_row_r == '0) && !in_ch.kind;
  assign w       = sample ? cw_clamp : act_w_r;
  assign h       = sample ? ch_clamp : act_h_r;
  assign h_r     = RW'(h);
  assign beyond  = in_row_r >= h_r;
  assign drop    = in_ch.kind && !beyond;
  assign col_ge3 = in_col_r >= WW'(3);
  assign k_ge3   = (in_row_r != '0) || col_ge3;
  assign hc_w    = col_ge3 ? in_col_r - WW'(3) : in_col_r + w - WW'(3);
  assign hrow    = col_ge3 ? in_row_r : in_row_r - RW'(1);
  assign hm6     = col_ge3 ? row_m6_r : ((row_m6_r == 3'd0) ? 3'd5 : row_m6_r - 3'd1);
  assign have_h  = k_ge3 && (hrow < h_r);
  assign have_v  = k_ge3 && (hrow >= RW'(3));
  assign orow    = hrow - RW'(3);
  assign last    = have_v && (orow == h_r - RW'(1)) && (hc_w == w - WW'(1));

  // Edge masks: a tap is used only if its row or column lies inside the frame.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hmask[j] = have_h && (hc_w >= WW'(3 - j));
      vmask[j] = orow >= RW'(3 - j);
    end
    hmask[3] = have_h;
    vmask[3] = 1'b1;
    for (int j = 4; j < 7; j++) begin
      hmask[j] = have_h && (({1'b0, hc_w} + (WW+1)'(j - 3)) < {1'b0, w});
      vmask[j] = ({1'b0, orow} + (RW+1)'(j - 3)) < {1'b0, h_r};
    end
  end

  always_comb begin
    q_entry        = '0;
    q_entry.pix    = beyond ? 16'd0 : in_ch.depth_in;
    q_entry.hc     = hc_w[CW-1:0];
    q_entry.hm6    = hm6;
    q_entry.have_h = have_h;
    q_entry.have_v = have_v;
    q_entry.last   = last;
    q_entry.hmask  = hmask;
    q_entry.vmask  = vmask;
  end

  assign q_push = accept && !drop;

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    row_m6_nxt = row_m6_r;
    if (q_push) begin
      if (last) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        row_m6_nxt = 3'd0;
      end else if (in_col_r + WW'(1) == w) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
        row_m6_nxt = (row_m6_r == 3'd5) ? 3'd0 : row_m6_r + 3'd1;
      end else begin
        in_col_nxt = in_col_r + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      row_m6_r <= 3'd0;
      act_w_r  <= WW'(640 > MAX_WIDTH ? MAX_WIDTH : 640);
      act_h_r  <= HW'(480 > MAX_HEIGHT ? MAX_HEIGHT : 480);
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      row_m6_r <= row_m6_nxt;
      if (q_push && sample) begin
        act_w_r <= cw_clamp;
        act_h_r <= ch_clamp;
      end
    end
  end

endmodule

FILE: rtl/core/sgdb_queue.sv
// Queue: short FIFO between the front end and the filter back end.
`timescale 1ns / 1ps

module sgdb_queue #(
  parameter int DEPTH = 4,
  parameter type entry_t = logic
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   nempty,
  output logic   full
);
  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  entry_t        slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign nempty = count_r != '0;
  assign full   = count_r == NW'(DEPTH);
  assign head   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop) rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop) count_r <= count_r + NW'(1);
      else if (pop && !push) count_r <= count_r - NW'(1);
    end
  end

endmodule

FILE: rtl/core/sgdb_back.sv
// Back end: row window, horizontal taps, line stores, vertical taps, output register.
`timescale 1ns / 1ps

module sgdb_back #(
  parameter int MAX_WIDTH = 1024,
  parameter type entry_t = logic
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sgdb_pkg::coef_t coefs,
  input  entry_t          q_head,
  input  logic            q_nempty,
  output logic            q_pop,
  sgdb_out_if.source      out_ch
);
  import sgdb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic        adv;
  logic [15:0] win_r [TAPS];
  logic [15:0] rd_q [NUM_SLOTS];

  logic        s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  entry_t      s1_r, s2_r, s3_r, s4_r;
  logic [15:0] hp_r [TAPS];
  logic [15:0] rd2_r [NUM_SLOTS];
  logic [15:0] hval, hval_r;
  logic [15:0] vp3_r [NUM_SLOTS];
  logic [15:0] vp4_r [TAPS];
  logic [15:0] vsum;
  logic        out_vld_r, out_last_r;
  logic [15:0] out_blur_r;

  logic          wr_en;
  logic [2:0]    wr_bank;
  logic [CW-1:0] wr_col;

  assign adv   = !out_vld_r || out_ch.ready;
  assign q_pop = adv && q_nempty;

  // Six row slots, one store each, all read at the column of the popped item.
  assign wr_en   = adv && s2_vld_r && s2_r.have_h;
  assign wr_bank = s2_r.hm6;
  assign wr_col  = s2_r.hc;

  for (genvar b = 0; b < NUM_SLOTS; b++) begin : g_bank
    logic [15:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 3'(b)) mem[wr_col] <= hval;
      if (q_pop) rd_q[b] <= mem[q_head.hc];
    end
  end

  always_comb begin
    hval = '0;
    for (int j = 0; j < TAPS; j++) hval = hval + hp_r[j];
    vsum = '0;
    for (int j = 0; j < TAPS; j++) vsum = vsum + vp4_r[j];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TAPS; j++) win_r[j] <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      if (q_pop) begin
        for (int j = 0; j < TAPS - 1; j++) win_r[j] <= win_r[j + 1];
        win_r[TAPS - 1] <= q_head.pix;
      end
      s1_vld_r  <= q_pop;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r && s4_r.have_v;
    end
  end

  always_ff @(posedge clk) begin
    logic [3:0] idx;
    if (adv) begin
      s1_r <= q_head;
      // S1 -> S2: horizontal products
      s2_r <= s1_r;
      for (int j = 0; j < TAPS; j++) begin
        hp_r[j] <= s1_r.hmask[j] ?
                   tap(coef_sel(coefs, 2'((j < 3) ? 3 - j : j - 3)), win_r[j]) : 16'd0;
      end
      for (int b = 0; b < NUM_SLOTS; b++) rd2_r[b] <= rd_q[b];
      // S2 -> S3: horizontal sum, products of the six stored rows
      s3_r   <= s2_r;
      hval_r <= hval;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        idx = {1'b0, s2_r.hm6} + 4'(i);
        if (idx >= 4'd6) idx = idx - 4'd6;
        vp3_r[i] <= s2_r.vmask[i] ?
                    tap(coef_sel(coefs, 2'((i < 3) ? 3 - i : i - 3)), rd2_r[idx[2:0]]) : 16'd0;
      end
      // S3 -> S4: newest row product
      s4_r <= s3_r;
      for (int i = 0; i < NUM_SLOTS; i++) vp4_r[i] <= vp3_r[i];
      vp4_r[TAPS - 1] <= s3_r.vmask[TAPS - 1] ? tap(coefs.c3, hval_r) : 16'd0;
      // S4 -> output register
      out_blur_r <= vsum;
      out_last_r <= s4_r.last;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.blurred    = out_blur_r;
  assign out_ch.frame_last = out_last_r;

endmodule
